@@ hw/rtl/retransmit_pending_table_assert.svh @@
// Assertion macros used by rpt_back. They expect clk and rst_n in scope.
`ifndef RETRANSMIT_PENDING_TABLE_ASSERT_SVH
`define RETRANSMIT_PENDING_TABLE_ASSERT_SVH

// Same-cycle implication.
`define RPT_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("rpt assertion failed");

// Next-cycle implication.
`define RPT_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("rpt assertion failed");

`endif

@@ hw/rtl/rpt_pkg.sv @@
package rpt_pkg;

    localparam int DEPTH = 8;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = 1;
    localparam int QCNT_W = 2;

    localparam logic [7:0]  CONTROL_TYPE     = 8'h01;
    localparam logic [31:0] US_PER_MS        = 32'd1000;
    localparam logic [15:0] RESET_TIMEOUT_MS = 16'd100;
    localparam logic [7:0]  RESET_RETRIES    = 8'd3;

    typedef enum logic [1:0] {
        OP_SEND = 2'd0,
        OP_ACK  = 2'd1,
        OP_DATA = 2'd2,
        OP_TICK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_RETX = 2'd1,
        KIND_ACK  = 2'd2,
        KIND_DROP = 2'd3
    } kind_t;

    localparam logic [1:0] CFG_ENABLE  = 2'd0;
    localparam logic [1:0] CFG_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_RETRIES = 2'd2;

    typedef struct packed {
        logic        enable;
        logic [31:0] limit_us;
        logic [7:0]  retry_limit;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  msg_code;
        logic [7:0]  tag;
        logic [15:0] length;
        logic [15:0] peer;
        logic [15:0] seq;
        logic [31:0] now;
    } cmd_t;

    typedef struct packed {
        logic [15:0] seq;
        logic [7:0]  msg_code;
        logic [7:0]  tag;
        logic [15:0] length;
        logic [31:0] sent;
        logic [7:0]  retries;
    } entry_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq;
        logic [15:0] acked;
        logic [7:0]  msg_code;
        logic        ctrl;
        logic [7:0]  tag;
        logic [15:0] length;
        logic        tracked;
        logic        last;
    } result_t;

endpackage

@@ hw/rtl/rpt_front.sv @@
module rpt_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    op,
    input  logic [7:0]    msg_code,
    input  logic [7:0]    payload_tag,
    input  logic [15:0]   payload_length,
    input  logic [15:0]   peer_sequence,
    input  logic [31:0]   now_us,
    input  logic          queue_full,
    output logic          push,
    output rpt_pkg::cmd_t push_cmd
);
    import rpt_pkg::*;

    logic [15:0] next_seq_reg, next_seq_next;
    op_t         op_in;
    logic        takes_seq;

    assign op_in     = op_t'(op);
    assign in_ready  = !queue_full;
    assign push      = in_valid && in_ready;
    // sends and received data each consume a sequence number
    assign takes_seq = (op_in == OP_SEND) || (op_in == OP_DATA);

    always_comb
    begin
        push_cmd.op       = op_in;
        push_cmd.msg_code = msg_code;
        push_cmd.tag      = payload_tag;
        push_cmd.length   = payload_length;
        push_cmd.peer     = peer_sequence;
        push_cmd.seq      = next_seq_reg;
        push_cmd.now      = now_us;
        next_seq_next     = next_seq_reg;
        if (push && takes_seq)
        begin
            next_seq_next = next_seq_reg + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_seq_reg <= 16'd1;
        end
        else
        begin
            next_seq_reg <= next_seq_next;
        end
    end

endmodule

@@ hw/rtl/rpt_queue.sv @@
module rpt_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  rpt_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output logic          empty,
    output rpt_pkg::cmd_t head
);
    import rpt_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ hw/rtl/rpt_back.sv @@
`include "retransmit_pending_table_assert.svh"

module rpt_back (
    input  logic             clk,
    input  logic             rst_n,
    input  rpt_pkg::cfg_t    cfg,
    input  logic             empty,
    input  rpt_pkg::cmd_t    head,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output rpt_pkg::result_t result
);
    import rpt_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ACK  = 3'b010,
        S_TICK = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] count_reg, count_next;
    entry_t         table_reg [DEPTH];
    entry_t         table_next [DEPTH];
    result_t        out_reg, out_next;
    logic           out_valid_reg, out_valid_next;
    result_t        hold_reg, hold_next;
    logic           hold_valid_reg, hold_valid_next;

    logic             can_emit;
    entry_t           cur;
    logic             in_range;
    logic [31:0]      age;
    logic             due;
    logic             ack_hit;
    logic             step_drop;
    logic             remove_en;
    logic [CNT_W-1:0] remove_idx;
    logic             trk;
    result_t          tick_res;

    assign can_emit  = !out_valid_reg || out_ready;
    assign cur       = table_reg[idx_reg[IDX_W-1:0]];
    assign in_range  = idx_reg < count_reg;
    assign age       = cmd_reg.now - cur.sent;
    assign due       = age >= cfg.limit_us;
    assign ack_hit   = in_range && (cur.seq == cmd_reg.peer);
    assign step_drop = in_range && due && (cur.retries >= cfg.retry_limit)
                       && (!hold_valid_reg || can_emit);
    assign trk       = cfg.enable && (count_reg < CNT_W'(DEPTH));

    assign out_valid = out_valid_reg;
    assign result    = out_reg;

    always_comb
    begin
        tick_res.kind     = (cur.retries < cfg.retry_limit) ? KIND_RETX : KIND_DROP;
        tick_res.seq      = cur.seq;
        tick_res.acked    = '0;
        tick_res.msg_code = cur.msg_code;
        tick_res.ctrl     = (cur.msg_code == CONTROL_TYPE);
        tick_res.tag      = cur.tag;
        tick_res.length   = cur.length;
        tick_res.tracked  = 1'b0;
        tick_res.last     = 1'b0;
    end

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        idx_next        = idx_reg;
        count_next      = count_reg;
        table_next      = table_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        hold_next       = hold_reg;
        hold_valid_next = hold_valid_reg;
        pop             = 1'b0;
        remove_en       = 1'b0;
        remove_idx      = idx_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    unique case (head.op)
                        OP_SEND:
                        begin
                            if (can_emit)
                            begin
                                pop = 1'b1;
                                if (trk)
                                begin
                                    table_next[count_reg[IDX_W-1:0]] =
                                        '{seq: head.seq, msg_code: head.msg_code,
                                          tag: head.tag, length: head.length,
                                          sent: head.now, retries: 8'd0};
                                    count_next = count_reg + 1'b1;
                                end
                                out_next = '{kind: KIND_TX, seq: head.seq, acked: 16'd0,
                                             msg_code: head.msg_code,
                                             ctrl: (head.msg_code == CONTROL_TYPE),
                                             tag: head.tag, length: head.length,
                                             tracked: trk, last: 1'b1};
                                out_valid_next = 1'b1;
                            end
                        end
                        OP_DATA:
                        begin
                            if (can_emit)
                            begin
                                pop = 1'b1;
                                out_next = '{kind: KIND_ACK, seq: head.seq,
                                             acked: head.peer, msg_code: 8'd0,
                                             ctrl: 1'b1, tag: 8'd0, length: 16'd0,
                                             tracked: 1'b0, last: 1'b1};
                                out_valid_next = 1'b1;
                            end
                        end
                        OP_ACK:
                        begin
                            pop        = 1'b1;
                            cmd_next   = head;
                            idx_next   = '0;
                            state_next = S_ACK;
                        end
                        default:
                        begin
                            pop = 1'b1;
                            if (cfg.enable)
                            begin
                                cmd_next   = head;
                                idx_next   = '0;
                                state_next = S_TICK;
                            end
                        end
                    endcase
                end
            end
            S_ACK:
            begin
                if (!in_range)
                begin
                    state_next = S_IDLE;
                end
                else if (ack_hit)
                begin
                    remove_en  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_TICK:
            begin
                if (!in_range)
                begin
                    // walk done: flush the held result as the final one
                    if (!hold_valid_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (can_emit)
                    begin
                        out_next        = hold_reg;
                        out_next.last   = 1'b1;
                        out_valid_next  = 1'b1;
                        hold_valid_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                end
                else if (!due)
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (!hold_valid_reg || can_emit)
                begin
                    if (hold_valid_reg)
                    begin
                        out_next       = hold_reg;
                        out_valid_next = 1'b1;
                    end
                    hold_next       = tick_res;
                    hold_valid_next = 1'b1;
                    if (cur.retries < cfg.retry_limit)
                    begin
                        table_next[idx_reg[IDX_W-1:0]].sent    = cmd_reg.now;
                        table_next[idx_reg[IDX_W-1:0]].retries = cur.retries + 8'd1;
                        idx_next = idx_reg + 1'b1;
                    end
                    else
                    begin
                        remove_en = 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // compaction: entries above the removed one move down by one
        if (remove_en)
        begin
            for (int j = 0; j < DEPTH - 1; j++)
            begin
                if (CNT_W'(j) >= remove_idx)
                begin
                    table_next[j] = table_reg[j + 1];
                end
            end
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        table_reg <= table_next;
        cmd_reg   <= cmd_next;
        out_reg   <= out_next;
        hold_reg  <= hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            idx_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    `RPT_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(DEPTH))
    `RPT_ASSERT_NEXT(a_ack_removes, state_reg == S_ACK && ack_hit, count_reg == $past(count_reg) - 1'b1 && state_reg == S_IDLE)
    `RPT_ASSERT_NEXT(a_drop_removes, state_reg == S_TICK && step_drop, count_reg == $past(count_reg) - 1'b1 && hold_valid_reg)
    `RPT_ASSERT_NOW(a_hold_in_tick, hold_valid_reg, state_reg == S_TICK)

endmodule

@@ hw/rtl/retransmit_pending_table.sv @@
// Retransmit pending table: sender side of an acknowledged link. Sends take
// a 16-bit sequence (first is 1, wraps) and give one transmit transfer; with
// retransmit_enable set they are also logged in an 8-entry ordered table, or
// reported untracked when it is full. A received data message gives one ack
// transfer with its own sequence. An ack/nack deletes the first matching
// entry and gives nothing. A tick walks the table: due entries are resent or,
// past the retry limit, dropped and reported; last flags the final transfer
// of the item. Flow: the front stamps sequences and writes a 2-deep command
// queue in the accepting cycle; the back pops one send or data command per
// cycle while the output register can take its result. An ack is popped,
// then scans one entry per cycle until a match or the end of the table. A
// tick is popped, then visits one entry per cycle and flushes the final held
// result, stalling while out_ready is low and a held result must go out.
// Each tick result is held back so that last can be set on the final one.
// Config writes are taken any time but must only happen while idle.
module retransmit_pending_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [7:0]  msg_code,
    input  logic [7:0]  payload_tag,
    input  logic [15:0] payload_length,
    input  logic [15:0] peer_sequence,
    input  logic [31:0] now_us,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] sequence_res,
    output logic [15:0] acked_sequence,
    output logic [7:0]  out_type,
    output logic        link_is_control,
    output logic [7:0]  out_tag,
    output logic [15:0] out_length,
    output logic        tracked,
    output logic        last
);
    import rpt_pkg::*;

    logic        enable_reg;
    logic [31:0] limit_reg;     // timeout in us, converted at write time
    logic [7:0]  retries_reg;
    cfg_t        cfg;

    logic    queue_full;
    logic    queue_empty;
    logic    push;
    logic    pop;
    cmd_t    push_cmd;
    cmd_t    head;
    result_t res;

    assign cfg = '{enable: enable_reg, limit_us: limit_reg, retry_limit: retries_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b0;
            limit_reg   <= 32'(RESET_TIMEOUT_MS) * US_PER_MS;
            retries_reg <= RESET_RETRIES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ENABLE:  enable_reg  <= cfg_data[0];
                CFG_TIMEOUT: limit_reg   <= 32'(cfg_data) * US_PER_MS;
                CFG_RETRIES: retries_reg <= cfg_data[7:0];
                default:     ;
            endcase
        end
    end

    rpt_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .msg_code       (msg_code),
        .payload_tag    (payload_tag),
        .payload_length (payload_length),
        .peer_sequence  (peer_sequence),
        .now_us         (now_us),
        .queue_full     (queue_full),
        .push           (push),
        .push_cmd       (push_cmd)
    );

    rpt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (queue_full),
        .pop      (pop),
        .empty    (queue_empty),
        .head     (head)
    );

    rpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .empty     (queue_empty),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (res)
    );

    // result transfer fields
    assign kind            = res.kind;
    assign sequence_res    = res.seq;
    assign acked_sequence  = res.acked;
    assign out_type        = res.msg_code;
    assign link_is_control = res.ctrl;
    assign out_tag         = res.tag;
    assign out_length      = res.length;
    assign tracked         = res.tracked;
    assign last            = res.last;

endmodule

@@ tb/sv/retransmit_pending_table_tb.sv @@
module retransmit_pending_table_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rpt_pkg::*;

    // Time-stamp classes picked per tick: the tb keeps a running clock and
    // steps it short of, right to or past the timeout, or sets it at random.
    typedef struct packed {
        op_t         op;
        logic [7:0]  msg_code;
        logic [7:0]  tag;
        logic [15:0] length;
        logic [15:0] peer;
        logic [31:0] now;
    } stim_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] seq;
        logic [15:0] acked;
        logic [7:0]  msg_code;
        logic        ctrl;
        logic [7:0]  tag;
        logic [15:0] length;
        logic        tracked;
        logic        last;
    } xfer_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_ENABLE;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  op = OP_SEND;
    logic [7:0]  msg_code = '0;
    logic [7:0]  payload_tag = '0;
    logic [15:0] payload_length = '0;
    logic [15:0] peer_sequence = '0;
    logic [31:0] now_us = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] sequence_res;
    logic [15:0] acked_sequence;
    logic [7:0]  out_type;
    logic        link_is_control;
    logic [7:0]  out_tag;
    logic [15:0] out_length;
    logic        tracked;
    logic        last;

    retransmit_pending_table uut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Mirror of the block's state, advanced when the driver's transfer lands.
    logic        mdl_enable;
    logic [15:0] mdl_timeout;
    logic [7:0]  mdl_retries;
    logic [15:0] mdl_next_seq;
    int          mdl_count;
    entry_t      mdl_tab[DEPTH];

    stim_t stim_q[$];
    xfer_t expected_q[$];
    int    errors = 0;

    // Mode flags shared with the driver/monitor processes.
    bit quiet_in = 0;      // no idling on either side
    int hold_left = 0;     // receiver holds off while nonzero, counted down by the monitor
    bit send_pause = 0;    // sender stops offering

    task automatic apply_cfg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ENABLE:  mdl_enable = val[0];
            CFG_TIMEOUT: mdl_timeout = val;
            default:     mdl_retries = val[7:0];
        endcase
    endtask

    function automatic xfer_t mk_entry_xfer(kind_t k, entry_t e);
        xfer_t x;
        x = '0;
        x.kind = k;
        x.seq = e.seq;
        x.msg_code = e.msg_code;
        x.ctrl = (e.msg_code == CONTROL_TYPE);
        x.tag = e.tag;
        x.length = e.length;
        return x;
    endfunction

    function automatic void delete_slot(int idx);
        for (int j = idx; j + 1 < mdl_count; j++)
            mdl_tab[j] = mdl_tab[j + 1];
        mdl_count--;
    endfunction

    // Work out the transfers one accepted item causes and queue them.
    function automatic void predict_item(stim_t s);
        xfer_t x;
        xfer_t batch[$];
        logic [31:0] limit;
        int i;
        x = '0;
        case (s.op)
            OP_SEND:
            begin
                x.kind = KIND_TX;
                x.seq = mdl_next_seq;
                x.msg_code = s.msg_code;
                x.ctrl = (s.msg_code == CONTROL_TYPE);
                x.tag = s.tag;
                x.length = s.length;
                if (mdl_enable && mdl_count < DEPTH)
                begin
                    mdl_tab[mdl_count] = '{mdl_next_seq, s.msg_code, s.tag,
                                           s.length, s.now, 8'd0};
                    mdl_count++;
                    x.tracked = 1'b1;
                end
                mdl_next_seq++;
                batch.push_back(x);
            end
            OP_ACK:
            begin
                for (i = 0; i < mdl_count; i++)
                    if (mdl_tab[i].seq == s.peer)
                    begin
                        delete_slot(i);
                        break;
                    end
            end
            OP_DATA:
            begin
                x.kind = KIND_ACK;
                x.seq = mdl_next_seq;
                x.acked = s.peer;
                x.ctrl = 1'b1;
                mdl_next_seq++;
                batch.push_back(x);
            end
            default:
            begin
                if (mdl_enable)
                begin
                    limit = 32'(mdl_timeout) * US_PER_MS;
                    i = 0;
                    while (i < mdl_count)
                    begin
                        if (s.now - mdl_tab[i].sent >= limit)
                        begin
                            if (mdl_tab[i].retries < mdl_retries)
                            begin
                                batch.push_back(mk_entry_xfer(KIND_RETX, mdl_tab[i]));
                                mdl_tab[i].sent = s.now;
                                mdl_tab[i].retries++;
                                i++;
                            end
                            else
                            begin
                                batch.push_back(mk_entry_xfer(KIND_DROP, mdl_tab[i]));
                                delete_slot(i);
                            end
                        end
                        else
                            i++;
                    end
                end
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            expected_q.push_back(batch[k]);
    endfunction

    // Driver: valid held with stable payload until the transfer.
    int watchdog = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_item(stim_q.pop_front());
                watchdog = 0;
            end
            if (!in_valid || in_ready)
            begin
                if (stim_q.size() > 0 && !send_pause &&
                    (quiet_in || $urandom_range(99) >= 22))
                begin
                    in_valid <= 1'b1;
                    op <= stim_q[0].op;
                    msg_code <= stim_q[0].msg_code;
                    payload_tag <= stim_q[0].tag;
                    payload_length <= stim_q[0].length;
                    peer_sequence <= stim_q[0].peer;
                    now_us <= stim_q[0].now;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare every transfer with the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                watchdog = 0;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transfer kind %0d seq %0d",
                             $realtime, kind, sequence_res);
                    errors++;
                end
                else
                begin
                    xfer_t e;
                    xfer_t a;
                    e = expected_q.pop_front();
                    a = '{kind_t'(kind), sequence_res, acked_sequence, out_type,
                          link_is_control, out_tag, out_length, tracked, last};
                    if (a !== e)
                    begin
                        $display("%0t: mismatch expected %h actual %h",
                                 $realtime, e, a);
                        errors++;
                    end
                end
            end
            if (hold_left > 0)
                hold_left--;
            out_ready <= (hold_left == 0) && (quiet_in || $urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        watchdog++;
        if (watchdog > 20000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus helpers.
    logic [31:0] clk_us = 32'd5000;

    function automatic stim_t mk_item(op_t o);
        stim_t s;
        s.op = o;
        s.msg_code = ($urandom_range(3) == 0) ? CONTROL_TYPE : 8'($urandom);
        s.tag = 8'($urandom);
        s.length = 16'($urandom);
        // mostly ack a live or recent sequence, sometimes anything
        s.peer = ($urandom_range(3) == 0) ? 16'($urandom)
                 : mdl_next_seq + 16'(stim_q.size()) - 16'($urandom_range(10));
        s.now = clk_us;
        return s;
    endfunction

    task automatic push_op(op_t o);
        stim_t s;
        s = mk_item(o);
        if (o == OP_TICK)
        begin
            // step time short of, right to or past the current timeout, or set it at random
            case ($urandom_range(3))
                0: clk_us = clk_us + 32'($urandom_range(999));
                1: clk_us = clk_us + 32'(mdl_timeout) * 1000;
                2: clk_us = clk_us + 32'(mdl_timeout) * 1000 + 32'($urandom_range(5000));
                default: clk_us = 32'($urandom);
            endcase
            s.now = clk_us;
        end
        stim_q.push_back(s);
    endtask

    task automatic drain();
        while (stim_q.size() > 0 || expected_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic random_phase(int n);
        int r;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(99);
            if (r < 45)      push_op(OP_SEND);
            else if (r < 65) push_op(OP_ACK);
            else if (r < 75) push_op(OP_DATA);
            else             push_op(OP_TICK);
        end
    endtask

    initial
    begin
        stim_t s;
        mdl_enable = 1'b0;
        mdl_timeout = RESET_TIMEOUT_MS;
        mdl_retries = RESET_RETRIES;
        mdl_next_seq = 16'd1;
        mdl_count = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset config, disabled tracking, disabled tick, data ack.
        push_op(OP_SEND);
        push_op(OP_TICK);
        s = mk_item(OP_DATA); s.peer = 16'hFFFF; stim_q.push_back(s);
        s = mk_item(OP_DATA); s.peer = 16'h0000; stim_q.push_back(s);
        s = mk_item(OP_ACK); s.peer = 16'd1; stim_q.push_back(s);
        drain();

        // Enable, timeout 0, retries 0: every entry is due and dropped at once.
        apply_cfg(CFG_ENABLE, 16'd1);
        apply_cfg(CFG_TIMEOUT, 16'd0);
        apply_cfg(CFG_RETRIES, 16'd0);
        for (int k = 0; k < 10; k++)
        begin
            // fill past full so the last sends are untracked
            s = mk_item(OP_SEND);
            s.msg_code = (k == 0) ? CONTROL_TYPE : (k == 1 ? 8'hFF : 8'h00);
            s.tag = (k[0]) ? 8'hFF : 8'h00;
            s.length = (k[0]) ? 16'hFFFF : 16'h0000;
            s.now = (k[0]) ? 32'hFFFF_FFFF : 32'h0;
            stim_q.push_back(s);
        end
        s = mk_item(OP_ACK); s.peer = mdl_next_seq + 16'd5; stim_q.push_back(s);
        s = mk_item(OP_ACK); s.peer = 16'hABCD; stim_q.push_back(s);
        push_op(OP_TICK);
        drain();

        // Max timeout and retries: ticks right at and just short of the limit.
        apply_cfg(CFG_TIMEOUT, 16'hFFFF);
        apply_cfg(CFG_RETRIES, 16'hFF);
        for (int k = 0; k < 6; k++)
            push_op(OP_SEND);
        s = mk_item(OP_TICK); s.now = clk_us + 32'd65535000; stim_q.push_back(s);
        s = mk_item(OP_TICK); s.now = clk_us + 32'd65534999; stim_q.push_back(s);
        drain();

        // Flush the table, then moderate timing for random traffic.
        apply_cfg(CFG_TIMEOUT, 16'd0);
        apply_cfg(CFG_RETRIES, 16'd0);
        push_op(OP_TICK);
        drain();
        apply_cfg(CFG_TIMEOUT, 16'd3);
        apply_cfg(CFG_RETRIES, 16'd2);

        // Back-pressure: receiver holds off while sends pile up.
        hold_left = 300;
        for (int k = 0; k < 12; k++)
            push_op(OP_SEND);
        while (hold_left > 0)
            @(posedge clk);
        drain();

        random_phase(50);
        drain();

        // Quiet stretch with no idling.
        quiet_in = 1;
        random_phase(50);
        drain();
        quiet_in = 0;

        apply_cfg(CFG_RETRIES, 16'd1);
        apply_cfg(CFG_TIMEOUT, 16'd1);
        random_phase(40);
        // sender waits until every result has come
        send_pause = 1;
        while (expected_q.size() > 0 || (in_valid && !in_ready))
            @(posedge clk);
        send_pause = 0;
        random_phase(40);
        drain();

        if (errors == 0 && expected_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/rpt_pkg.sv
hw/rtl/rpt_front.sv
hw/rtl/rpt_queue.sv
hw/rtl/rpt_back.sv
hw/rtl/retransmit_pending_table.sv
tb/sv/retransmit_pending_table_tb.sv
